// File: hdl/srld_pkg.sv
// Shared types and constants for the sprite run-length decoder.
// Depends on nothing; the core, the parser and the output stage in hdl/ import it.
`default_nettype none

package srld_pkg;

  localparam int unsigned WordW   = 16;
  localparam int unsigned StatusW = 3;
  localparam int unsigned PixW    = 10;
  localparam int unsigned CursorW = 11;
  localparam logic [CursorW-1:0] CursorMax = 11'd2047;

  typedef enum logic [2:0] {
    PH_HEAD  = 3'd0,
    PH_TABLE = 3'd1,
    PH_SKIP  = 3'd2,
    PH_RUN   = 3'd3,
    PH_COLOR = 3'd4,
    PH_STOP  = 3'd5
  } phase_e;

  typedef enum logic [StatusW-1:0] {
    ST_PIXEL        = 3'd0,
    ST_DONE         = 3'd1,
    ST_BAD_SIZE     = 3'd2,
    ST_EARLY_END    = 3'd3,
    ST_ROW_MISMATCH = 3'd4,
    ST_X_OVERFLOW   = 3'd5
  } status_e;

  // Word in flight between the parser and the output stage.
  typedef struct packed {
    logic              valid;     // a result or a table compare is pending
    logic              cmp;       // result depends on the table read
    status_e           status;
    logic [PixW-1:0]   x;
    logic [PixW-1:0]   y;
    logic [WordW-1:0]  color;
    logic [WordW-1:0]  expect_ofs;
    logic              fwd;       // table entry written in the same cycle
    logic [WordW-1:0]  fwd_data;
  } srld_s2_t;

endpackage

`default_nettype wire

// File: hdl/sprite_run_length_decoder_core.sv
// Sprite run-length decoder, top level. Uses srld_pkg, srld_ram, srld_parser, srld_out.
// Pipeline: an accepted word passes through the parser register, then the
// result register, which drives the outputs.
// Throughput: one word per cycle when not stalled; the single read port of the
// offset table serves one row-start compare per word, resolved in the output stage.
// Reset (async, active low) clears the parser and the pipeline valid bits;
// the offset table is not cleared and holds garbage until a record fills it.
`default_nettype none

module sprite_run_length_decoder_core #(
  parameter int unsigned MAX_DIM   = 1024,
  parameter int unsigned END_LIMIT = 2048
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input word channel
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [15:0] word_i,
  input  wire logic        first_word_i,
  // result word channel
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic      [2:0]  status_o,
  output logic      [9:0]  pixel_x_o,
  output logic      [9:0]  pixel_y_o,
  output logic      [15:0] color_o
);

  import srld_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_DIM);

  logic             adv;
  logic             accept;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [WordW-1:0] ram_wdata;
  logic [AddrW-1:0] ram_raddr;
  logic [WordW-1:0] ram_rdata;
  srld_s2_t         s2;

  // Advance the whole pipe only when the result register can take a word;
  // otherwise hold every stage, including the table read data.
  assign stall_o = !adv;
  assign accept  = valid_i && adv;

  srld_parser #(
    .MAX_DIM   (MAX_DIM),
    .END_LIMIT (END_LIMIT)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .accept_i     (accept),
    .word_i       (word_i),
    .first_word_i (first_word_i),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_raddr_o  (ram_raddr),
    .s2_o         (s2)
  );

  // Row offset table: written during the table phase, read at its end and at each row end.
  // A read of the entry written in the same cycle is forwarded by the parser.
  srld_ram #(
    .WIDTH (WordW),
    .DEPTH (MAX_DIM)
  ) u_ofs_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (adv),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  srld_out u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s2_i      (s2),
    .rdata_i   (ram_rdata),
    .stall_i   (stall_i),
    .adv_o     (adv),
    .valid_o   (valid_o),
    .status_o  (status_o),
    .pixel_x_o (pixel_x_o),
    .pixel_y_o (pixel_y_o),
    .color_o   (color_o)
  );

endmodule

`default_nettype wire

// File: hdl/srld_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
`default_nettype none

module srld_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hdl/srld_parser.sv
// Record parser: header, offset table writes, skip/run/colour sequencing.
// Depends on srld_pkg; drives the offset table RAM ports.
`default_nettype none

module srld_parser #(
  parameter int unsigned MAX_DIM   = 1024,
  parameter int unsigned END_LIMIT = 2048
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       adv_i,
  input  wire logic                       accept_i,
  input  wire logic [15:0]                word_i,
  input  wire logic                       first_word_i,
  output logic                            ram_we_o,
  output logic      [$clog2(MAX_DIM)-1:0] ram_waddr_o,
  output logic      [15:0]                ram_wdata_o,
  output logic      [$clog2(MAX_DIM)-1:0] ram_raddr_o,
  output srld_pkg::srld_s2_t              s2_o
);

  import srld_pkg::*;

  localparam int unsigned DimW = $clog2(MAX_DIM);
  localparam logic [16:0] MaxDim17 = 17'(MAX_DIM);
  localparam logic [16:0] EndLim17 = 17'(END_LIMIT);

  phase_e              phase_q, phase_d;
  logic [WordW-1:0]    pos_q, pos_d;
  logic [DimW-1:0]     width_q, width_d;
  logic [DimW-1:0]     height_q, height_d;
  logic [CursorW-1:0]  cx_q, cx_d;
  logic [DimW-1:0]     cy_q, cy_d;
  logic [WordW-1:0]    skip_q, skip_d;
  logic [WordW-1:0]    run_q, run_d;
  srld_s2_t            s2_q, s2_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEAD;
      pos_q    <= '0;
      width_q  <= '0;
      height_q <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      skip_q   <= '0;
      run_q    <= '0;
      s2_q     <= '0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      width_q  <= width_d;
      height_q <= height_d;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      skip_q   <= skip_d;
      run_q    <= run_d;
      s2_q     <= s2_d;
    end
  end

  always_comb begin
    phase_e           ph;
    logic [WordW-1:0] pos;
    logic [WordW-1:0] idx;
    logic [16:0]      sum;
    logic [16:0]      cx_sum;
    logic [DimW:0]    y1;
    logic [11:0]      cx_inc;
    logic             res;
    status_e          st;
    logic             cmp;
    logic [WordW-1:0] expect_ofs;

    phase_d  = phase_q;
    pos_d    = pos_q;
    width_d  = width_q;
    height_d = height_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    skip_d   = skip_q;
    run_d    = run_q;
    s2_d     = s2_q;

    ph         = first_word_i ? PH_HEAD : phase_q;
    pos        = first_word_i ? '0 : pos_q;
    idx        = pos - 16'd4;
    sum        = {1'b0, skip_q} + {1'b0, word_i};
    cx_sum     = 17'(cx_q) + {1'b0, skip_q};
    y1         = {1'b0, cy_q} + 1'b1;
    cx_inc     = {1'b0, cx_q} + 12'd1;
    res        = 1'b0;
    st         = ST_PIXEL;
    cmp        = 1'b0;
    expect_ofs = '0;

    ram_we_o    = 1'b0;
    ram_waddr_o = idx[DimW-1:0];
    ram_wdata_o = word_i;
    ram_raddr_o = '0;

    if (accept_i) begin
      phase_d = ph;
      pos_d   = pos + 16'd1;
      case (ph)
        PH_HEAD: begin
          if (pos == 16'd2 || pos == 16'd3) begin
            if (word_i == '0 || {1'b0, word_i} >= MaxDim17) begin
              res     = 1'b1;
              st      = ST_BAD_SIZE;
              phase_d = PH_STOP;
            end else if (pos == 16'd2) begin
              width_d = word_i[DimW-1:0];
            end else begin
              height_d = word_i[DimW-1:0];
              phase_d  = PH_TABLE;
            end
          end
        end
        PH_TABLE: begin
          ram_we_o = {1'b0, idx} < 17'(height_q);
          if ({1'b0, idx} + 17'd1 >= 17'(height_q)) begin
            phase_d     = PH_SKIP;
            cx_d        = '0;
            cy_d        = '0;
            cmp         = 1'b1;
            ram_raddr_o = '0;
          end
        end
        PH_SKIP: begin
          skip_d  = word_i;
          phase_d = PH_RUN;
        end
        PH_RUN: begin
          if (sum >= EndLim17) begin
            res     = 1'b1;
            st      = ST_EARLY_END;
            phase_d = PH_STOP;
          end else if (sum != '0) begin
            cx_d = (cx_sum > 17'(CursorMax)) ? CursorMax : cx_sum[CursorW-1:0];
            if (word_i != '0) begin
              run_d   = word_i;
              phase_d = PH_COLOR;
            end else begin
              phase_d = PH_SKIP;
            end
          end else begin
            // End of row: move down and, unless the image is done, check the next row's start offset.
            cx_d = '0;
            cy_d = y1[DimW-1:0];
            if (y1 >= {1'b0, height_q}) begin
              res     = 1'b1;
              st      = ST_DONE;
              phase_d = PH_STOP;
            end else begin
              cmp         = 1'b1;
              ram_raddr_o = y1[DimW-1:0];
              expect_ofs  = pos + 16'd1 - 16'd4 - 16'(height_q);
              phase_d     = PH_SKIP;
            end
          end
        end
        PH_COLOR: begin
          res  = 1'b1;
          st   = (17'(cx_q) < 17'(width_q)) ? ST_PIXEL : ST_X_OVERFLOW;
          cx_d = (cx_inc > 12'(CursorMax)) ? CursorMax : cx_inc[CursorW-1:0];
          run_d = run_q - 16'd1;
          if (run_q == 16'd1) begin
            phase_d = PH_SKIP;
          end
        end
        default: begin
        end
      endcase
    end

    if (adv_i) begin
      s2_d.valid      = accept_i && (res || cmp);
      s2_d.cmp        = cmp;
      s2_d.status     = st;
      s2_d.x          = (st == ST_PIXEL) ? cx_q[PixW-1:0] : '0;
      s2_d.y          = (st == ST_PIXEL) ? PixW'(cy_q) : '0;
      s2_d.color      = (st == ST_PIXEL) ? word_i : '0;
      s2_d.expect_ofs = expect_ofs;
      s2_d.fwd        = ram_we_o && (ram_waddr_o == ram_raddr_o);
      s2_d.fwd_data   = word_i;
    end
  end

  assign s2_o = s2_q;

endmodule

`default_nettype wire

// File: hdl/srld_out.sv
// Output stage: resolves row offset compares and holds the result register.
// Depends on srld_pkg; takes the offset table read data.
`default_nettype none

module srld_out (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire srld_pkg::srld_s2_t s2_i,
  input  wire logic [15:0]        rdata_i,
  input  wire logic               stall_i,
  output logic                    adv_o,
  output logic                    valid_o,
  output logic      [2:0]         status_o,
  output logic      [9:0]         pixel_x_o,
  output logic      [9:0]         pixel_y_o,
  output logic      [15:0]        color_o
);

  import srld_pkg::*;

  logic             valid_q, valid_d;
  status_e          status_q, status_d;
  logic [PixW-1:0]  x_q, x_d;
  logic [PixW-1:0]  y_q, y_d;
  logic [WordW-1:0] color_q, color_d;
  logic [WordW-1:0] ofs;

  assign adv_o = !valid_q || !stall_i;
  assign ofs   = s2_i.fwd ? s2_i.fwd_data : rdata_i;

  always_comb begin
    valid_d  = valid_q;
    status_d = status_q;
    x_d      = x_q;
    y_d      = y_q;
    color_d  = color_q;
    if (adv_o) begin
      if (s2_i.cmp) begin
        valid_d  = s2_i.valid && (ofs != s2_i.expect_ofs);
        status_d = ST_ROW_MISMATCH;
        x_d      = '0;
        y_d      = '0;
        color_d  = '0;
      end else begin
        valid_d  = s2_i.valid;
        status_d = s2_i.status;
        x_d      = s2_i.x;
        y_d      = s2_i.y;
        color_d  = s2_i.color;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    x_q      <= x_d;
    y_q      <= y_d;
    color_q  <= color_d;
  end

  assign valid_o   = valid_q;
  assign status_o  = status_q;
  assign pixel_x_o = x_q;
  assign pixel_y_o = y_q;
  assign color_o   = color_q;

endmodule

`default_nettype wire

// File: tb/sv/sprite_run_length_decoder_core_tb.sv
// Self-checking testbench for the sprite run-length decoder core.
// Uses srld_pkg for the phase and status codes; needs only the RTL in hdl/.
module sprite_run_length_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srld_pkg::*;

  localparam int unsigned MaxDim     = 1024;
  localparam int unsigned EndLimit   = 2048;
  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned PhaseWords = 150;
  localparam int unsigned MaxPrints  = 200;

  // How a directed row is checked: by the decoder model, by a value typed in, or as giving no result.
  typedef enum logic [1:0] {
    CHK_MODEL  = 2'd0,
    CHK_QUIET  = 2'd1,
    CHK_RESULT = 2'd2
  } chk_e;

  typedef struct packed {
    status_e          status;
    logic [9:0]       x;
    logic [9:0]       y;
    logic [15:0]      color;
  } pixel_word_t;

  typedef struct packed {
    logic [15:0] word;
    logic        first;
  } record_word_t;

  typedef struct packed {
    logic [15:0] word;
    logic        first;
    chk_e        chk;
    status_e     status;
    logic [9:0]  x;
    logic [9:0]  y;
    logic [15:0] color;
  } dir_row_t;

  // Directed words: power-up without a restart mark, a zero width, a too-large
  // width and height, a full one-row image at the widest size with a pixel and
  // an x overflow, a row-0 offset mismatch and an early end.
  localparam dir_row_t DirectedRows [30] = '{
    '{16'hFFFF, 1'b0, CHK_QUIET,  ST_PIXEL,        10'd0,    10'd0, 16'h0000},
    '{16'h0000, 1'b0, CHK_QUIET,  ST_PIXEL,        10'd0,    10'd0, 16'h0000},
    '{16'h0000, 1'b0, CHK_RESULT, ST_BAD_SIZE,     10'd0,    10'd0, 16'h0000},
    '{16'h1234, 1'b0, CHK_QUIET,  ST_PIXEL,        10'd0,    10'd0, 16'h0000},
    '{16'h0000, 1'b1, CHK_QUIET,  ST_PIXEL,        10'd0,    10'd0, 16'h0000},
    '{16'hFFFF, 1'b0, CHK_QUIET,  ST_PIXEL,        10'd0,    10'd0, 16'h0000},
    '{16'h0400, 1'b0, CHK_RESULT, ST_BAD_SIZE,     10'd0,    10'd0, 16'h0000},
    '{16'h0001, 1'b1, CHK_QUIET,  ST_PIXEL,        10'd0,    10'd0, 16'h0000},
    '{16'h0002, 1'b0, CHK_QUIET,  ST_PIXEL,        10'd0,    10'd0, 16'h0000},
    '{16'h03FF, 1'b0, CHK_QUIET,  ST_PIXEL,        10'd0,    10'd0, 16'h0000},
    '{16'hFFFF, 1'b0, CHK_RESULT, ST_BAD_SIZE,     10'd0,    10'd0, 16'h0000},
    '{16'hAAAA, 1'b1, CHK_QUIET,  ST_PIXEL,        10'd0,    10'd0, 16'h0000},
    '{16'h5555, 1'b0, CHK_QUIET,  ST_PIXEL,        10'd0,    10'd0, 16'h0000},
    '{16'h03FF, 1'b0, CHK_QUIET,  ST_PIXEL,        10'd0,    10'd0, 16'h0000},
    '{16'h0001, 1'b0, CHK_QUIET,  ST_PIXEL,        10'd0,    10'd0, 16'h0000},
    '{16'h0000, 1'b0, CHK_QUIET,  ST_PIXEL,        10'd0,    10'd0, 16'h0000},
    '{16'h03FE, 1'b0, CHK_MODEL,  ST_PIXEL,        10'd0,    10'd0, 16'h0000},
    '{16'h0002, 1'b0, CHK_MODEL,  ST_PIXEL,        10'd0,    10'd0, 16'h0000},
    '{16'hFFFF, 1'b0, CHK_RESULT, ST_PIXEL,        10'd1022, 10'd0, 16'hFFFF},
    '{16'h0000, 1'b0, CHK_RESULT, ST_X_OVERFLOW,   10'd0,    10'd0, 16'h0000},
    '{16'h0000, 1'b0, CHK_QUIET,  ST_PIXEL,        10'd0,    10'd0, 16'h0000},
    '{16'h0000, 1'b0, CHK_RESULT, ST_DONE,         10'd0,    10'd0, 16'h0000},
    '{16'h0000, 1'b1, CHK_QUIET,  ST_PIXEL,        10'd0,    10'd0, 16'h0000},
    '{16'h0000, 1'b0, CHK_QUIET,  ST_PIXEL,        10'd0,    10'd0, 16'h0000},
    '{16'h0001, 1'b0, CHK_QUIET,  ST_PIXEL,        10'd0,    10'd0, 16'h0000},
    '{16'h0002, 1'b0, CHK_QUIET,  ST_PIXEL,        10'd0,    10'd0, 16'h0000},
    '{16'h0001, 1'b0, CHK_QUIET,  ST_PIXEL,        10'd0,    10'd0, 16'h0000},
    '{16'h0009, 1'b0, CHK_RESULT, ST_ROW_MISMATCH, 10'd0,    10'd0, 16'h0000},
    '{16'h07FF, 1'b0, CHK_QUIET,  ST_PIXEL,        10'd0,    10'd0, 16'h0000},
    '{16'h0001, 1'b0, CHK_RESULT, ST_EARLY_END,    10'd0,    10'd0, 16'h0000}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        valid_i;
  logic        stall_o;
  logic [15:0] word_i;
  logic        first_word_i;
  logic        valid_o;
  logic        stall_i;
  logic [2:0]  status_o;
  logic [9:0]  pixel_x_o;
  logic [9:0]  pixel_y_o;
  logic [15:0] color_o;

  sprite_run_length_decoder_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .stall_o     (stall_o),
    .word_i      (word_i),
    .first_word_i(first_word_i),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .status_o    (status_o),
    .pixel_x_o   (pixel_x_o),
    .pixel_y_o   (pixel_y_o),
    .color_o     (color_o)
  );

  // Decoder model state, kept apart from the block.
  phase_e      dec_phase;
  logic [15:0] dec_pos;
  logic [9:0]  dec_width;
  logic [9:0]  dec_height;
  logic [15:0] dec_offsets [MaxDim];
  int unsigned dec_cx;
  int unsigned dec_cy;
  logic [15:0] dec_skip;
  logic [15:0] dec_run_left;

  pixel_word_t  pending_pixels [$];
  record_word_t record_words [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned error_count;
  int unsigned results_seen;
  int unsigned cycle_count;

  // Free-running clock, 10 ns period.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Give up on a hung block: report failure once the cycle budget is spent.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_pixels.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Count a mismatch; print only the first few hundred so the log stays short.
  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    error_count++;
    if (error_count <= MaxPrints)
      $display("mismatch on result %0d, %s: got 0x%0h, want 0x%0h", results_seen, what,
               got, want);
  endtask

  function automatic int unsigned clamp_cursor(input int unsigned v);
    return (v > int'(CursorMax)) ? int'(CursorMax) : v;
  endfunction

  // Advance the decoder model by one word; report the result word it causes.
  task automatic decode_word(input logic [15:0] w, input logic first, output bit has,
                             output pixel_word_t res);
    logic [15:0] pos;
    logic [15:0] idx;
    logic [15:0] next_ofs;
    int unsigned sum;
    has = 1'b0;
    res = '0;
    // A restart mark rewinds to word 0 from any phase, the stopped one too.
    if (first) begin
      dec_phase = PH_HEAD;
      dec_pos   = '0;
    end
    pos     = dec_pos;
    dec_pos = pos + 16'd1;
    case (dec_phase)
      PH_HEAD: begin
        // Words 0 and 1 carry nothing; 2 is the width and 3 the height.
        if (pos == 16'd2 || pos == 16'd3) begin
          if (w == 16'd0 || w >= MaxDim) begin
            has        = 1'b1;
            res.status = ST_BAD_SIZE;
            dec_phase  = PH_STOP;
          end else if (pos == 16'd2) begin
            dec_width = w[9:0];
          end else begin
            dec_height = w[9:0];
            dec_phase  = PH_TABLE;
          end
        end
      end
      PH_TABLE: begin
        idx = pos - 16'd4;
        if (idx < dec_height) dec_offsets[idx[9:0]] = w;
        // On the last table word, row 0 must start right after the table.
        if (32'(idx) + 32'd1 >= 32'(dec_height)) begin
          dec_phase = PH_SKIP;
          dec_cx    = 0;
          dec_cy    = 0;
          if (dec_offsets[0] != 16'd0) begin
            has        = 1'b1;
            res.status = ST_ROW_MISMATCH;
          end
        end
      end
      PH_SKIP: begin
        dec_skip  = w;
        dec_phase = PH_RUN;
      end
      PH_RUN: begin
        sum = 32'(dec_skip) + 32'(w);
        if (sum >= EndLimit) begin
          has        = 1'b1;
          res.status = ST_EARLY_END;
          dec_phase  = PH_STOP;
        end else if (sum != 0) begin
          dec_cx = clamp_cursor(dec_cx + 32'(dec_skip));
          if (w != 16'd0) begin
            dec_run_left = w;
            dec_phase    = PH_COLOR;
          end else begin
            dec_phase = PH_SKIP;
          end
        end else begin
          // End of row: either the image is done or the next row must start
          // at the offset that the table holds for it.
          dec_cx = 0;
          dec_cy = dec_cy + 1;
          if (dec_cy >= 32'(dec_height)) begin
            has        = 1'b1;
            res.status = ST_DONE;
            dec_phase  = PH_STOP;
          end else begin
            next_ofs = pos + 16'd1 - 16'd4 - {6'd0, dec_height};
            if (next_ofs != dec_offsets[dec_cy[9:0]]) begin
              has        = 1'b1;
              res.status = ST_ROW_MISMATCH;
            end
            dec_phase = PH_SKIP;
          end
        end
      end
      PH_COLOR: begin
        has = 1'b1;
        if (dec_cx < 32'(dec_width)) begin
          res.status = ST_PIXEL;
          res.x      = 10'(dec_cx);
          res.y      = 10'(dec_cy);
          res.color  = w;
        end else begin
          res.status = ST_X_OVERFLOW;
        end
        dec_cx       = clamp_cursor(dec_cx + 1);
        dec_run_left = dec_run_left - 16'd1;
        if (dec_run_left == 16'd0) dec_phase = PH_SKIP;
      end
      default: begin
      end
    endcase
  endtask

  // Offer one word at the falling edge, hold it until accepted, then log what
  // it should produce. Returns at the following falling edge.
  task automatic drive_word(input record_word_t rw, input chk_e chk,
                            input pixel_word_t typed);
    bit          has;
    pixel_word_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(negedge clk_i);
    end
    valid_i      <= 1'b1;
    word_i       <= rw.word;
    first_word_i <= rw.first;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    decode_word(rw.word, rw.first, has, res);
    case (chk)
      CHK_MODEL:  if (has) pending_pixels = {pending_pixels, res};
      CHK_RESULT: pending_pixels = {pending_pixels, typed};
      default: begin
      end
    endcase
    @(negedge clk_i);
  endtask

  // Build one sprite record into record_words: mostly well formed with random
  // content, sometimes with a bad size, a wrong offset, an early end, a cut
  // short record or trailing noise. n_words excludes the noise.
  task automatic build_record(output int unsigned n_words);
    int unsigned  kind;
    int unsigned  width;
    int unsigned  height;
    int unsigned  rows;
    int unsigned  nseg;
    int unsigned  skip;
    int unsigned  run;
    int unsigned  r;
    int unsigned  s;
    int unsigned  k;
    bit           wide;
    bit           cut_early;
    logic [15:0]  bad;
    logic [15:0]  row_data [$];
    logic [15:0]  offsets [$];
    record_word_t rec [$];
    kind = $urandom_range(99);
    rec = {rec, record_word_t'{16'($urandom), 1'b1}};
    rec = {rec, record_word_t'{16'($urandom), 1'b0}};
    bad    = ($urandom_range(1) == 1) ? 16'd0 : 16'($urandom_range(1024, 65535));
    width  = (kind < 15) ? $urandom_range(1, 1023) : $urandom_range(1, 48);
    height = (kind >= 8 && kind < 11) ? $urandom_range(200, 1023) : $urandom_range(1, 6);
    if (kind < 4) begin
      rec = {rec, record_word_t'{bad, 1'b0}};
    end else begin
      rec = {rec, record_word_t'{16'(width), 1'b0}};
      if (kind < 8) begin
        rec = {rec, record_word_t'{bad, 1'b0}};
      end else begin
        rec = {rec, record_word_t'{16'(height), 1'b0}};
        // Tall images get a few rows and then an early end.
        rows      = (height > 6) ? 3 : height;
        cut_early = (height > 6) || ($urandom_range(99) < 6);
        for (r = 0; r < rows; r++) begin
          offsets = {offsets, 16'(row_data.size())};
          if (cut_early && r == rows - 1) begin
            row_data = {row_data, 16'($urandom)};
            row_data = {row_data, 16'($urandom_range(EndLimit, 65535))};
            break;
          end
          nseg = $urandom_range(0, 3);
          wide = ($urandom_range(99) < 6);
          for (s = 0; s < nseg; s++) begin
            if (wide || $urandom_range(99) < 5) begin
              skip = $urandom_range(1500, 2040);
              run  = $urandom_range(0, 3);
            end else begin
              skip = $urandom_range(0, 8);
              run  = $urandom_range(0, 6);
            end
            if (skip + run == 0) run = 1;
            row_data = {row_data, 16'(skip)};
            row_data = {row_data, 16'(run)};
            for (k = 0; k < run; k++) row_data = {row_data, 16'($urandom)};
          end
          row_data = {row_data, 16'd0};
          row_data = {row_data, 16'd0};
        end
        while (offsets.size() < height) offsets = {offsets, 16'($urandom)};
        if ($urandom_range(99) < 10) begin
          k = $urandom_range(0, offsets.size() - 1);
          offsets[k] = offsets[k] ^ (16'd1 << $urandom_range(0, 15));
        end
        foreach (offsets[i]) rec = {rec, record_word_t'{offsets[i], 1'b0}};
        foreach (row_data[i]) rec = {rec, record_word_t'{row_data[i], 1'b0}};
      end
    end
    n_words = rec.size();
    if ($urandom_range(99) < 8) n_words = $urandom_range(1, rec.size());
    for (k = 0; k < n_words; k++) record_words = {record_words, rec[k]};
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(1, 4)) begin
        record_words = {record_words, record_word_t'{16'($urandom), 1'b0}};
      end
    end
  endtask

  // Receiver: stall at the falling edge with the phase's probability.
  always @(negedge clk_i) begin
    stall_i <= rst_ni && ($urandom_range(99) < recv_stall_pct);
  end

  // Check every accepted result word against the oldest prediction.
  always @(posedge clk_i) begin
    pixel_word_t want;
    if (rst_ni && valid_o && !stall_i) begin
      if (pending_pixels.size() == 0) begin
        flag_mismatch("unexpected result, status", status_o, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (status_o != want.status) flag_mismatch("status", status_o, want.status);
        if (pixel_x_o != want.x) flag_mismatch("pixel_x", pixel_x_o, want.x);
        if (pixel_y_o != want.y) flag_mismatch("pixel_y", pixel_y_o, want.y);
        if (color_o != want.color) flag_mismatch("color", color_o, want.color);
      end
      results_seen++;
    end
  end

  initial begin
    record_word_t rw;
    pixel_word_t  typed;
    int unsigned  n_words;
    int unsigned  sent;
    int unsigned  phase_idx;
    // Drive every input to a known value before the first edge.
    rst_ni         = 1'b0;
    valid_i        = 1'b0;
    word_i         = '0;
    first_word_i   = 1'b0;
    stall_i        = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    error_count    = 0;
    results_seen   = 0;
    cycle_count    = 0;
    dec_phase      = PH_HEAD;
    dec_pos        = '0;
    dec_width      = '0;
    dec_height     = '0;
    dec_cx         = 0;
    dec_cy         = 0;
    dec_skip       = '0;
    dec_run_left   = '0;
    foreach (dec_offsets[i]) dec_offsets[i] = '0;

    // Hold reset, then release it at a falling edge.
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed words, no idling on either side.
    foreach (DirectedRows[i]) begin
      rw    = '{DirectedRows[i].word, DirectedRows[i].first};
      typed = '{DirectedRows[i].status, DirectedRows[i].x, DirectedRows[i].y,
                DirectedRows[i].color};
      drive_word(rw, DirectedRows[i].chk, typed);
    end

    // Random records, in four idling phases: none, sender idle, receiver
    // stalling, both.
    for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
      case (phase_idx)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      sent = 0;
      while (sent < PhaseWords) begin
        build_record(n_words);
        sent += n_words;
        while (record_words.size() != 0) begin
          rw = record_words.pop_front();
          drive_word(rw, CHK_MODEL, '0);
        end
      end
    end
    valid_i <= 1'b0;

    // Drain: wait for every predicted word, then wait on for stray results.
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
